// ===== design/fdbd_pkg.sv =====
// Package for the four-digit blinking display: transaction types, codes and helpers.
package fdbd_pkg;

    localparam int NUM_DIGITS = 4;

    // operation codes
    localparam logic [2:0] OP_SET_NUMBER  = 3'd0;
    localparam logic [2:0] OP_START_BLINK = 3'd1;
    localparam logic [2:0] OP_STOP_BLINK  = 3'd2;
    localparam logic [2:0] OP_CLEAR_BLINK = 3'd3;
    localparam logic [2:0] OP_TICK        = 3'd4;

    localparam logic [15:0] BLINK_RESET_MS = 16'd500;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
    localparam logic [13:0] DISPLAY_MOD    = 14'd10000;
    localparam logic [13:0] WEIGHT_1000    = 14'd1000;
    localparam logic [13:0] WEIGHT_100     = 14'd100;
    localparam logic [13:0] WEIGHT_10      = 14'd10;

    typedef struct packed {
        logic [2:0]  operation;
        logic [13:0] value;
        logic [1:0]  digit_index;
        logic [15:0] interval_ms;
    } t_in_item;

    typedef struct packed {
        logic [6:0] segments_0;
        logic [6:0] segments_1;
        logic [6:0] segments_2;
        logic [6:0] segments_3;
        logic [3:0] blinking_digits;
    } t_out_item;

    // input transaction after the first split step
    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  thousands;
        logic [9:0]  rem_1000;
        logic [1:0]  digit_index;
        logic [15:0] interval_ms;
    } t_dec_item;

    // decimal digit of v at a constant weight, v < 10 * weight
    function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] w);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 14'(k) * w) begin
                cnt = 4'(k);
            end
        end
        return cnt;
    endfunction

    // segment pattern, bit0 = a .. bit6 = g
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] pat;
        case (d)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/fdbd_core.sv =====
// Display state and per-transaction update: digits, blink mask, visibility, timers.
module fdbd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fdbd_pkg::t_dec_item i_item,
    output fdbd_pkg::t_out_item o_result
);

    logic [3:0]  r_digit [fdbd_pkg::NUM_DIGITS];
    logic [3:0]  r_blink_en;
    logic [3:0]  r_visible;
    logic [15:0] r_interval [fdbd_pkg::NUM_DIGITS];
    logic [15:0] r_elapsed [fdbd_pkg::NUM_DIGITS];

    logic [3:0]  n_digit [fdbd_pkg::NUM_DIGITS];
    logic [3:0]  n_blink_en;
    logic [3:0]  n_visible;
    logic [15:0] n_interval [fdbd_pkg::NUM_DIGITS];
    logic [15:0] n_elapsed [fdbd_pkg::NUM_DIGITS];

    logic [3:0]  w_hundreds;
    logic [6:0]  w_rem_100;
    logic [3:0]  w_tens;
    logic [3:0]  w_ones;
    logic [6:0]  w_seg [fdbd_pkg::NUM_DIGITS];

    // remaining digits from the value below 1000
    assign w_hundreds = fdbd_pkg::dec_digit({4'd0, i_item.rem_1000}, fdbd_pkg::WEIGHT_100);
    assign w_rem_100  = 7'({4'd0, i_item.rem_1000}
                           - 14'(w_hundreds) * fdbd_pkg::WEIGHT_100);
    assign w_tens     = fdbd_pkg::dec_digit({7'd0, w_rem_100}, fdbd_pkg::WEIGHT_10);
    assign w_ones     = 4'({7'd0, w_rem_100} - 14'(w_tens) * fdbd_pkg::WEIGHT_10);

    always_comb begin
        logic [15:0] inc;
        for (int i = 0; i < fdbd_pkg::NUM_DIGITS; i++) begin
            n_digit[i]    = r_digit[i];
            n_interval[i] = r_interval[i];
            n_elapsed[i]  = r_elapsed[i];
        end
        n_blink_en = r_blink_en;
        n_visible  = r_visible;
        inc        = '0;
        case (i_item.operation)
            fdbd_pkg::OP_SET_NUMBER: begin
                n_digit[0] = i_item.thousands;
                n_digit[1] = w_hundreds;
                n_digit[2] = w_tens;
                n_digit[3] = w_ones;
            end
            fdbd_pkg::OP_START_BLINK: begin
                n_blink_en[i_item.digit_index] = 1'b1;
                n_interval[i_item.digit_index] = i_item.interval_ms;
                n_elapsed[i_item.digit_index]  = '0;
            end
            fdbd_pkg::OP_STOP_BLINK: begin
                n_blink_en[i_item.digit_index] = 1'b0;
                n_visible[i_item.digit_index]  = 1'b1;
            end
            fdbd_pkg::OP_CLEAR_BLINK: begin
                n_blink_en = '0;
                n_visible  = '1;
            end
            fdbd_pkg::OP_TICK: begin
                // every timer advances up to its top; a blinking digit at its interval toggles
                for (int i = 0; i < fdbd_pkg::NUM_DIGITS; i++) begin
                    inc = (r_elapsed[i] == fdbd_pkg::ELAPSED_MAX) ? r_elapsed[i]
                                                                  : r_elapsed[i] + 16'd1;
                    n_elapsed[i] = inc;
                    if (r_blink_en[i] && (inc >= r_interval[i])) begin
                        n_elapsed[i] = '0;
                        n_visible[i] = ~r_visible[i];
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < fdbd_pkg::NUM_DIGITS; i++) begin
            w_seg[i] = (n_blink_en[i] && !n_visible[i]) ? 7'd0
                                                       : fdbd_pkg::seg_pattern(n_digit[i]);
        end
    end

    assign o_result.segments_0      = w_seg[0];
    assign o_result.segments_1      = w_seg[1];
    assign o_result.segments_2      = w_seg[2];
    assign o_result.segments_3      = w_seg[3];
    assign o_result.blinking_digits = n_blink_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fdbd_pkg::NUM_DIGITS; i++) begin
                r_digit[i]    <= '0;
                r_interval[i] <= fdbd_pkg::BLINK_RESET_MS;
                r_elapsed[i]  <= '0;
            end
            r_blink_en <= '0;
            r_visible  <= '1;
        end else if (i_en) begin
            for (int i = 0; i < fdbd_pkg::NUM_DIGITS; i++) begin
                r_digit[i]    <= n_digit[i];
                r_interval[i] <= n_interval[i];
                r_elapsed[i]  <= n_elapsed[i];
            end
            r_blink_en <= n_blink_en;
            r_visible  <= n_visible;
        end
    end

endmodule

// ===== design/four_digit_blinking_display_top.sv =====
// Top level of the four-digit blinking seven-segment display.
// Path: input register, then result register.
// Throughput: one transaction per cycle unless output stalls; each input yields one result.
// Reset: synchronous, active low; digits zero, no blinking, all visible, intervals 500 ms.
// Reset empties both pipeline registers, so the input is not stalled when reset ends.
module four_digit_blinking_display_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fdbd_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fdbd_pkg::t_out_item o_out_data
);

    // stage 1: input register, holds the value already reduced mod 10000
    // and split into its thousands digit plus the remainder below 1000
    logic                r_in_valid;
    fdbd_pkg::t_dec_item r_in;
    fdbd_pkg::t_dec_item n_in;

    // stage 2: result register
    logic                r_out_valid;
    fdbd_pkg::t_out_item r_out;

    logic                w_adv;      // result register can take a new transaction
    logic                w_fire;     // stage 1 transaction moves into the state/result
    logic                w_in_acc;   // input transaction accepted this edge
    logic [13:0]         w_mod;
    logic [3:0]          w_th;
    fdbd_pkg::t_out_item w_result;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    // stall only when stage 1 is full and the result cannot leave
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // values above 9999 wrap once (input stays below twice the modulus)
    assign w_mod = (i_in_data.value >= fdbd_pkg::DISPLAY_MOD)
                 ? i_in_data.value - fdbd_pkg::DISPLAY_MOD
                 : i_in_data.value;
    assign w_th  = fdbd_pkg::dec_digit(w_mod, fdbd_pkg::WEIGHT_1000);

    always_comb begin
        n_in.operation   = i_in_data.operation;
        n_in.thousands   = w_th;
        n_in.rem_1000    = 10'(w_mod - 14'(w_th) * fdbd_pkg::WEIGHT_1000);
        n_in.digit_index = i_in_data.digit_index;
        n_in.interval_ms = i_in_data.interval_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= n_in;
        end
    end

    // state update happens exactly when the transaction enters the result register
    fdbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/fdbd_checker.sv =====
// Port-level checker for the four-digit blinking display, bound to the top level.
module fdbd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fdbd_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fdbd_pkg::t_out_item o_out_data
);

    // stalled input transaction stays offered with its payload unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input transaction changed while stalled");

    // stalled result stays offered
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // stalled result payload holds
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // input backpressure only comes from a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a digit that is not blinking is never blank
    a_steady_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.blinking_digits[0] || o_out_data.segments_0 != 7'd0) &&
            (o_out_data.blinking_digits[1] || o_out_data.segments_1 != 7'd0) &&
            (o_out_data.blinking_digits[2] || o_out_data.segments_2 != 7'd0) &&
            (o_out_data.blinking_digits[3] || o_out_data.segments_3 != 7'd0))
        else $error("steady digit shown blank");

endmodule

bind four_digit_blinking_display_top fdbd_checker u_fdbd_checker (.*);

// ===== tb/display_checker.sv =====
// Checker for the four-digit blinking display: predicts each result and compares it.
module display_checker
    import fdbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_toggles
);
    timeunit 1ns;
    timeprecision 1ps;

    // segment patterns, bit0 = a .. bit6 = g
    localparam logic [6:0] SEG_LUT [0:9] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic [3:0]  shown_digit [NUM_DIGITS];
    logic [3:0]  blink_mask;
    logic [3:0]  lit_mask;
    logic [15:0] toggle_ms [NUM_DIGITS];
    logic [15:0] ms_count [NUM_DIGITS];
    t_out_item   frames_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_toggles    = 0;
    end

    task automatic advance_display(input t_in_item cmd, output t_out_item frame);
        logic [13:0] shown_value;
        logic [6:0]  pat [NUM_DIGITS];
        shown_value = cmd.value % DISPLAY_MOD;
        case (cmd.operation)
            OP_SET_NUMBER: begin
                shown_digit[0] = 4'(shown_value / WEIGHT_1000);
                shown_digit[1] = 4'((shown_value / WEIGHT_100) % WEIGHT_10);
                shown_digit[2] = 4'((shown_value / WEIGHT_10) % WEIGHT_10);
                shown_digit[3] = 4'(shown_value % WEIGHT_10);
            end
            OP_START_BLINK: begin
                // visibility left alone on a restart
                blink_mask[cmd.digit_index] = 1'b1;
                toggle_ms[cmd.digit_index]  = cmd.interval_ms;
                ms_count[cmd.digit_index]   = '0;
            end
            OP_STOP_BLINK: begin
                blink_mask[cmd.digit_index] = 1'b0;
                lit_mask[cmd.digit_index]   = 1'b1;
            end
            OP_CLEAR_BLINK: begin
                blink_mask = '0;
                lit_mask   = '1;
            end
            OP_TICK: begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (ms_count[i] != ELAPSED_MAX) begin
                        ms_count[i] = ms_count[i] + 16'd1;
                    end
                    if (blink_mask[i] && ms_count[i] >= toggle_ms[i]) begin
                        ms_count[i] = '0;
                        lit_mask[i] = ~lit_mask[i];
                        o_toggles++;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_DIGITS; i++) begin
            pat[i] = (blink_mask[i] && !lit_mask[i]) ? 7'h00 : SEG_LUT[shown_digit[i]];
        end
        frame.segments_0      = pat[0];
        frame.segments_1      = pat[1];
        frame.segments_2      = pat[2];
        frame.segments_3      = pat[3];
        frame.blinking_digits = blink_mask;
    endtask

    task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item frame;
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                shown_digit[i] = '0;
                toggle_ms[i]   = BLINK_RESET_MS;
                ms_count[i]    = '0;
            end
            blink_mask = '0;
            lit_mask   = '1;
            frames_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    $error("result 0x%h with no transaction pending", i_out_data);
                    o_fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("segments_0", want.segments_0, i_out_data.segments_0);
                    check_field("segments_1", want.segments_1, i_out_data.segments_1);
                    check_field("segments_2", want.segments_2, i_out_data.segments_2);
                    check_field("segments_3", want.segments_3, i_out_data.segments_3);
                    check_field("blinking_digits", 7'(want.blinking_digits),
                                7'(i_out_data.blinking_digits));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_display(i_in_data, frame);
                frames_due.push_back(frame);
            end
        end
        o_pending = frames_due.size();
    end

endmodule

// ===== tb/tb_four_digit_blinking_display_top.sv =====
// Testbench top for the four-digit blinking display: stimulus, idling and verdict.
module tb_four_digit_blinking_display_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fdbd_pkg::*;

    // codes the block must ignore
    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 900;
    localparam int LONG_TICKS   = 60;      // a couple of toggles at the intervals below
    localparam int DRAIN_CYCLES = 8;       // margin after the last result has drained
    localparam int TIMEOUT_NS   = 5_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int checked;
    int toggles;

    // run-wide knobs shared by the sender and the receiver
    bit quiet;       // last part of the run: no idling on either side
    int idle_pct;    // chance of a sender gap before a transaction
    int n_items;
    int n_ticks;

    four_digit_blinking_display_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    display_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_toggles    (toggles)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stretches of free flow broken by stall bursts.
    // Driven at the falling edge, one assignment per edge.
    initial begin : stall_gen
        int run;
        i_out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 11);
            if (quiet || $urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 20)) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end else begin
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall = !quiet;
                end
            end
        end
    end

    function automatic t_in_item make_cmd(input logic [2:0] op, input logic [13:0] v,
                                          input logic [1:0] d, input logic [15:0] ms);
        t_in_item cmd;
        cmd.operation   = op;
        cmd.value       = v;
        cmd.digit_index = d;
        cmd.interval_ms = ms;
        return cmd;
    endfunction

    // Mostly ticks and short-interval blink starts so digits actually toggle;
    // unused fields carry random junk.
    function automatic t_in_item random_cmd();
        t_in_item cmd;
        int pick;
        cmd = make_cmd(OP_TICK, 14'($urandom), 2'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            cmd.operation = OP_TICK;
        end else if (pick < 62) begin
            cmd.operation = OP_START_BLINK;
            case ($urandom_range(0, 9))
                0:       ;   // full-range interval
                1, 2:    cmd.interval_ms = 16'($urandom_range(7, 40));
                default: cmd.interval_ms = 16'($urandom_range(0, 6));
            endcase
        end else if (pick < 70) begin
            cmd.operation = OP_STOP_BLINK;
        end else if (pick < 74) begin
            cmd.operation = OP_CLEAR_BLINK;
        end else if (pick < 95) begin
            cmd.operation = OP_SET_NUMBER;
            if ($urandom_range(0, 1) == 0) begin
                cmd.value = 14'($urandom_range(0, 9999));
            end
        end else begin
            case ($urandom_range(0, 2))
                0:       cmd.operation = OP_UNUSED_5;
                1:       cmd.operation = OP_UNUSED_6;
                default: cmd.operation = OP_UNUSED_7;
            endcase
        end
        return cmd;
    endfunction

    // Present one transaction at the falling edge, optionally after a gap,
    // and hold it until the block takes it.
    task automatic send(input t_in_item cmd);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            repeat ($urandom_range(1, 11)) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = cmd;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        n_items++;
        if (cmd.operation == OP_TICK) begin
            n_ticks++;
        end
    endtask

    initial begin : stimulus
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        quiet      = 1'b0;
        idle_pct   = 25;
        n_items    = 0;
        n_ticks    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: number extremes and wrap above 9999
        send(make_cmd(OP_SET_NUMBER, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_SET_NUMBER, 14'd9999, 2'd3, 16'hFFFF));
        send(make_cmd(OP_SET_NUMBER, 14'd10000, 2'd1, 16'd0));
        send(make_cmd(OP_SET_NUMBER, 14'h3FFF, 2'd2, 16'hFFFF));
        send(make_cmd(OP_SET_NUMBER, 14'd1234, 2'd0, 16'd0));
        // zero interval: toggles on every tick
        send(make_cmd(OP_START_BLINK, 14'h3FFF, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        // interval of two on the rightmost digit
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd3, 16'd2));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        // restart on a digit already blinking (and hidden): visibility kept
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd0, 16'hFFFF));
        send(make_cmd(OP_STOP_BLINK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd1, 16'd1));
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd2, 16'd3));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        // ignored codes, one with every field at its top
        send(make_cmd(OP_UNUSED_5, 14'd5, 2'd1, 16'd5));
        send(make_cmd(OP_UNUSED_6, 14'd0, 2'd2, 16'd0));
        send(make_cmd(OP_UNUSED_7, 14'h3FFF, 2'd3, 16'hFFFF));
        send(make_cmd(OP_CLEAR_BLINK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));

        // Random body; sender gap rate changes every 50 transactions,
        // including stretches with no gaps at all.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            send(random_cmd());
        end

        // Last part, no idling: back-to-back ticks with two digits toggling
        // on longer intervals, then a fresh start on another digit.
        quiet    = 1'b1;
        idle_pct = 0;
        send(make_cmd(OP_CLEAR_BLINK, 14'd0, 2'd0, 16'd0));
        send(make_cmd(OP_SET_NUMBER, 14'd8642, 2'd0, 16'd0));
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd1, 16'd25));
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd2, 16'd24));
        for (n = 0; n < LONG_TICKS; n++) begin
            send(make_cmd(OP_TICK, 14'($urandom), 2'($urandom), 16'($urandom)));
        end
        send(make_cmd(OP_START_BLINK, 14'd0, 2'd0, 16'd3));
        for (n = 0; n < 6; n++) begin
            send(make_cmd(OP_TICK, 14'd0, 2'd0, 16'd0));
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        // drain: every result in, then a little extra for anything stray
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions, %0d of them 1 ms ticks.", n_items, n_ticks);
        $display("Compared %0d display results; %0d blink toggles predicted.", checked, toggles);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fdbd_pkg.sv
design/fdbd_core.sv
design/four_digit_blinking_display_top.sv
design/fdbd_checker.sv
tb/display_checker.sv
tb/tb_four_digit_blinking_display_top.sv
